// ===== rtl/core/dpb_pkg.sv =====
package dpb_pkg;

    localparam int DEPTH_W = 16;
    localparam int POS_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int INV_W   = 24;
    localparam int CEN_W   = 16;
    localparam int COORD_W = 40;
    localparam int MAG_W   = 16;
    localparam int MD_W    = MAG_W + DEPTH_W;
    localparam int PROD_W  = MD_W + INV_W;
    localparam int FRAC_SH = 20;
    localparam int Q_W     = PROD_W + 1 - FRAC_SH;
    localparam int GREY_W  = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRINSICS_LOADED = 3'd5;

    localparam logic [INV_W-1:0] RST_INV_FOCAL_X = 24'd33554;
    localparam logic [INV_W-1:0] RST_INV_FOCAL_Y = 24'd33554;
    localparam logic [CEN_W-1:0] RST_CENTER_X    = 16'd5120;
    localparam logic [CEN_W-1:0] RST_CENTER_Y    = 16'd3840;

    localparam logic [GREY_W-1:0] GREY_R     = 22'd4899;
    localparam logic [GREY_W-1:0] GREY_G     = 22'd9617;
    localparam logic [GREY_W-1:0] GREY_B     = 22'd1868;
    localparam logic [GREY_W-1:0] GREY_ROUND = 22'd8192;

    localparam logic [PROD_W:0]  ROUND_HALF = (PROD_W+1)'(1) << (FRAC_SH - 1);
    localparam logic [COORD_W:0] POS_LIMIT  = 41'h07F_FFFF_FFFF;
    localparam logic [COORD_W:0] NEG_LIMIT  = 41'h080_0000_0000;
    localparam logic [COORD_W-1:0] COORD_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 40'h80_0000_0000;

    typedef struct packed {
        logic [INV_W-1:0] inv_focal_x;
        logic [INV_W-1:0] inv_focal_y;
        logic [CEN_W-1:0] center_x;
        logic [CEN_W-1:0] center_y;
        logic             colour_mode;
        logic             intrinsics_loaded;
    } t_cfg;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [POS_W-1:0]   pixel_col;
        logic [POS_W-1:0]   pixel_row;
        logic [CHAN_W-1:0]  blue_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  red_in;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [CHAN_W-1:0]         blue_out;
        logic [CHAN_W-1:0]         green_out;
        logic [CHAN_W-1:0]         red_out;
    } t_rsp;

    typedef struct packed {
        logic [MAG_W-1:0]   mag_x;
        logic               neg_x;
        logic [MAG_W-1:0]   mag_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [CHAN_W-1:0]  grey;
    } t_s1;

    typedef struct packed {
        logic [MD_W-1:0]    md_x;
        logic               neg_x;
        logic [MD_W-1:0]    md_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [CHAN_W-1:0]  grey;
    } t_s2;

    typedef struct packed {
        logic [PROD_W-1:0]  prod_x;
        logic               neg_x;
        logic [PROD_W-1:0]  prod_y;
        logic               neg_y;
        logic [DEPTH_W-1:0] depth;
        logic [CHAN_W-1:0]  grey;
    } t_s3;

endpackage

// ===== rtl/core/depth_pixel_backprojection_core.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         i_req_valid / o_req_ready    i_req (t_req)
// response  out        o_rsp_valid / i_rsp_ready    o_rsp (t_rsp)
// config    in         i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One request enters per cycle unless a stall backs up; it passes s1, s2, s3 and output regs.
// The offset by depth by inverse focal length product, split over two multiplier stages,
// sets the x and y coordinates.
// Requests with zero depth, outside the image, or without loaded intrinsics leave no response.
// Reset is synchronous and active low; it empties the pipeline and restores the config registers.
// A stall at the output only holds stages that are full; empty stages keep taking requests.
module depth_pixel_backprojection_core
    import dpb_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int DEPTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp
);

    t_cfg cfg;
    logic s1_valid;
    logic s1_ready;
    t_s1  s1;
    logic s3_valid;
    logic s3_ready;
    t_s3  s3;

    dpb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dpb_front #(
        .MAX_DIM    (MAX_DIM),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_s1_valid  (s1_valid),
        .i_s1_ready  (s1_ready),
        .o_s1        (s1)
    );

    dpb_mult u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .o_s1_ready (s1_ready),
        .i_s1       (s1),
        .o_s3_valid (s3_valid),
        .i_s3_ready (s3_ready),
        .o_s3       (s3)
    );

    dpb_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s3_valid  (s3_valid),
        .o_s3_ready  (s3_ready),
        .i_s3        (s3),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== rtl/core/dpb_cfg_regs.sv =====
module dpb_cfg_regs
    import dpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_FOCAL_X:       n_cfg.inv_focal_x = i_cfg_data[INV_W-1:0];
                CFG_INV_FOCAL_Y:       n_cfg.inv_focal_y = i_cfg_data[INV_W-1:0];
                CFG_CENTER_X:          n_cfg.center_x = i_cfg_data[CEN_W-1:0];
                CFG_CENTER_Y:          n_cfg.center_y = i_cfg_data[CEN_W-1:0];
                CFG_COLOUR_MODE:       n_cfg.colour_mode = i_cfg_data[0];
                CFG_INTRINSICS_LOADED: n_cfg.intrinsics_loaded = i_cfg_data[0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_focal_x       <= RST_INV_FOCAL_X;
            r_cfg.inv_focal_y       <= RST_INV_FOCAL_Y;
            r_cfg.center_x          <= RST_CENTER_X;
            r_cfg.center_y          <= RST_CENTER_Y;
            r_cfg.colour_mode       <= 1'b0;
            r_cfg.intrinsics_loaded <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/dpb_front.sv =====
module dpb_front
    import dpb_pkg::*;
#(
    parameter int MAX_DIM    = 4096,
    parameter int DEPTH_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_s1_valid,
    input  logic i_s1_ready,
    output t_s1  o_s1
);

    localparam logic [DEPTH_W-1:0] DEPTH_MASK = DEPTH_W'((33'd1 << DEPTH_BITS) - 33'd1);

    logic               r_s1_valid;
    t_s1                r_s1;
    t_s1                n_s1;
    logic [DEPTH_W-1:0] depth_m;
    logic               in_range;
    logic               keep;
    logic [CEN_W:0]     diff_x;
    logic [CEN_W:0]     diff_y;
    logic [GREY_W-1:0]  grey_sum;

    always_comb begin
        depth_m  = i_req.depth_mm & DEPTH_MASK;
        in_range = (32'(i_req.pixel_col) < 32'(MAX_DIM)) &&
                   (32'(i_req.pixel_row) < 32'(MAX_DIM));
        keep     = i_cfg.intrinsics_loaded && (depth_m != '0) && in_range;

        diff_x = {1'b0, i_req.pixel_col, 4'b0000} - {1'b0, i_cfg.center_x};
        diff_y = {1'b0, i_req.pixel_row, 4'b0000} - {1'b0, i_cfg.center_y};

        grey_sum = GREY_R * GREY_W'(i_req.red_in) + GREY_G * GREY_W'(i_req.green_in)
                 + GREY_B * GREY_W'(i_req.blue_in) + GREY_ROUND;

        n_s1.neg_x = diff_x[CEN_W];
        n_s1.mag_x = diff_x[CEN_W] ? MAG_W'(-diff_x) : diff_x[MAG_W-1:0];
        n_s1.neg_y = diff_y[CEN_W];
        n_s1.mag_y = diff_y[CEN_W] ? MAG_W'(-diff_y) : diff_y[MAG_W-1:0];
        n_s1.depth = depth_m;
        n_s1.grey  = i_cfg.colour_mode ? grey_sum[GREY_W-1 -: CHAN_W] : '0;
    end

    assign o_req_ready = !r_s1_valid || i_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_s1_valid <= i_req_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// ===== rtl/core/dpb_mult.sv =====
module dpb_mult
    import dpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_s1_valid,
    output logic o_s1_ready,
    input  t_s1  i_s1,
    output logic o_s3_valid,
    input  logic i_s3_ready,
    output t_s3  o_s3
);

    logic r_s2_valid;
    logic r_s3_valid;
    t_s2  r_s2;
    t_s3  r_s3;
    logic s2_ready;

    assign s2_ready   = !r_s3_valid || i_s3_ready;
    assign o_s1_ready = !r_s2_valid || s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (o_s1_ready) begin
                r_s2_valid <= i_s1_valid;
            end
            if (s2_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_valid) begin
            r_s2.md_x  <= MD_W'(i_s1.mag_x) * MD_W'(i_s1.depth);
            r_s2.md_y  <= MD_W'(i_s1.mag_y) * MD_W'(i_s1.depth);
            r_s2.neg_x <= i_s1.neg_x;
            r_s2.neg_y <= i_s1.neg_y;
            r_s2.depth <= i_s1.depth;
            r_s2.grey  <= i_s1.grey;
        end
        if (s2_ready && r_s2_valid) begin
            r_s3.prod_x <= PROD_W'(r_s2.md_x) * PROD_W'(i_cfg.inv_focal_x);
            r_s3.prod_y <= PROD_W'(r_s2.md_y) * PROD_W'(i_cfg.inv_focal_y);
            r_s3.neg_x  <= r_s2.neg_x;
            r_s3.neg_y  <= r_s2.neg_y;
            r_s3.depth  <= r_s2.depth;
            r_s3.grey   <= r_s2.grey;
        end
    end

    assign o_s3_valid = r_s3_valid;
    assign o_s3       = r_s3;

endmodule

// ===== rtl/core/dpb_round.sv =====
module dpb_round
    import dpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s3_valid,
    output logic o_s3_ready,
    input  t_s3  i_s3,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic r_valid;
    t_rsp r_rsp;
    t_rsp n_rsp;

    function automatic logic [COORD_W-1:0] round_sat(logic [PROD_W-1:0] prod, logic neg);
        logic [PROD_W:0]    sum;
        logic [Q_W-1:0]     q;
        logic [COORD_W:0]   q_ext;
        logic [COORD_W-1:0] res;
        sum   = {1'b0, prod} + ROUND_HALF;
        q     = sum[PROD_W:FRAC_SH];
        q_ext = (COORD_W+1)'(q);
        if (!neg) begin
            res = (q_ext > POS_LIMIT) ? COORD_MAX : q_ext[COORD_W-1:0];
        end else begin
            res = (q_ext > NEG_LIMIT) ? COORD_MIN : COORD_W'(-q_ext);
        end
        return res;
    endfunction

    always_comb begin
        n_rsp.point_x   = round_sat(i_s3.prod_x, i_s3.neg_x);
        n_rsp.point_y   = round_sat(i_s3.prod_y, i_s3.neg_y);
        n_rsp.point_z   = i_s3.depth;
        n_rsp.blue_out  = i_s3.grey;
        n_rsp.green_out = i_s3.grey;
        n_rsp.red_out   = i_s3.grey;
    end

    assign o_s3_ready = !r_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s3_ready) begin
            r_valid <= i_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s3_ready && i_s3_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== rtl/core/dpb_checker.sv =====
module dpb_checker
    import dpb_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("Response changed or dropped while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("Response valid right after reset.");

    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.point_z != '0)
        else $error("Response carries zero depth.");

    a_grey_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.blue_out == o_rsp.green_out) &&
                        (o_rsp.green_out == o_rsp.red_out))
        else $error("Colour channels of a response differ.");

endmodule

bind depth_pixel_backprojection_core dpb_checker u_dpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
